/* rtl/tpdf_pkg.sv */
// ----------------------------------------------------------------------------
// TCP port drop filter package
// Shared types, codes and sizes of the filter's front, queue and back parts.
// ----------------------------------------------------------------------------
package tpdf_pkg;

    localparam int COUNTER_WIDTH_DEFAULT = 64;
    localparam int STAT_WIDTH            = 64;
    localparam int OUT_FIELDS_WIDTH      = 1 + 4 * STAT_WIDTH;
    localparam int OUT_TDATA_WIDTH       = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;
    localparam int IN_TDATA_WIDTH        = 8;
    localparam int CFG_INDEX_WIDTH       = 1;
    localparam int CFG_DATA_WIDTH        = 16;
    localparam int QUEUE_DEPTH           = 4;
    localparam int QUEUE_PTR_WIDTH       = $clog2(QUEUE_DEPTH);
    localparam int OFFSET_WIDTH          = 7;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_DROP_PORT    = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_PORT_ENABLED = 1'b1;

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX       = 7'd127;
    localparam logic [OFFSET_WIDTH-1:0] OFF_ETHTYPE_HI   = 7'd12;
    localparam logic [OFFSET_WIDTH-1:0] OFF_ETHTYPE_LO   = 7'd13;
    localparam logic [OFFSET_WIDTH-1:0] OFF_IP_IHL       = 7'd14;
    localparam logic [OFFSET_WIDTH-1:0] OFF_IP_PROTO     = 7'd23;
    localparam logic [OFFSET_WIDTH-1:0] ETH_HDR_LEN      = 7'd14;
    localparam logic [OFFSET_WIDTH:0]   ETH_MIN_LEN      = 8'd14;
    localparam logic [OFFSET_WIDTH:0]   IPV4_MIN_LEN     = 8'd34;
    localparam logic [OFFSET_WIDTH:0]   TCP_MIN_LEN      = 8'd20;
    localparam logic [15:0]             ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]              PROTO_TCP        = 8'd6;

    typedef enum logic [2:0] {
        CLS_SHORT,
        CLS_PASS,
        CLS_TCP_SHORT,
        CLS_TCP_PASS,
        CLS_TCP_DROP
    } t_frame_class;

    typedef struct packed {
        logic [15:0] drop_port;
        logic        port_enabled;
    } t_cfg;

endpackage

/* rtl/tpdf_parser.sv */
// ----------------------------------------------------------------------------
// TCP port drop filter front end
// Takes frame bytes, extracts header fields and classifies each frame at its
// last byte into one request for the statistics back end.
// ----------------------------------------------------------------------------
module tpdf_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tpdf_pkg::t_cfg                    i_cfg,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [tpdf_pkg::IN_TDATA_WIDTH-1:0] i_s_tdata,  // data_byte
    input  logic                              i_s_tlast,
    input  logic                              i_queue_full,
    output logic                              o_push,
    output tpdf_pkg::t_frame_class            o_push_class
);

    localparam int OW = tpdf_pkg::OFFSET_WIDTH;

    logic [OW-1:0] r_offset,       n_offset;
    logic [15:0]   r_ether_kind,   n_ether_kind;
    logic [7:0]    r_ip_protocol,  n_ip_protocol;
    logic [3:0]    r_header_words, n_header_words;
    logic [15:0]   r_sport,        n_sport;
    logic [15:0]   r_dst_port,     n_dst_port;

    logic [OW-1:0] tcp_at;
    logic [OW:0]   frame_len;
    logic [OW:0]   tcp_end;
    logic          accept;
    logic          port_match;

    assign o_s_tready = !i_queue_full;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_ether_kind   = r_ether_kind;
        n_ip_protocol  = r_ip_protocol;
        n_header_words = r_header_words;
        n_sport        = r_sport;
        n_dst_port     = r_dst_port;

        if (r_offset == tpdf_pkg::OFF_ETHTYPE_HI) begin
            n_ether_kind[15:8] = i_s_tdata;
        end else if (r_offset == tpdf_pkg::OFF_ETHTYPE_LO) begin
            n_ether_kind[7:0] = i_s_tdata;
        end
        if (r_offset == tpdf_pkg::OFF_IP_IHL) begin
            n_header_words = i_s_tdata[3:0];
        end
        if (r_offset == tpdf_pkg::OFF_IP_PROTO) begin
            n_ip_protocol = i_s_tdata;
        end

        tcp_at = tpdf_pkg::ETH_HDR_LEN + {1'b0, n_header_words, 2'b00};
        if (r_offset == tcp_at) begin
            n_sport[15:8] = i_s_tdata;
        end else if (r_offset == tcp_at + 7'd1) begin
            n_sport[7:0] = i_s_tdata;
        end else if (r_offset == tcp_at + 7'd2) begin
            n_dst_port[15:8] = i_s_tdata;
        end else if (r_offset == tcp_at + 7'd3) begin
            n_dst_port[7:0] = i_s_tdata;
        end

        if (r_offset < tpdf_pkg::OFFSET_MAX) begin
            n_offset = r_offset + 7'd1;
        end else begin
            n_offset = r_offset;
        end
    end

    always_comb begin
        frame_len  = {1'b0, r_offset} + 8'd1;
        tcp_end    = {1'b0, tcp_at} + tpdf_pkg::TCP_MIN_LEN;
        port_match = (n_dst_port == i_cfg.drop_port) ||
                     (n_sport == i_cfg.drop_port);

        if (frame_len < tpdf_pkg::ETH_MIN_LEN) begin
            o_push_class = tpdf_pkg::CLS_SHORT;
        end else if (n_ether_kind != tpdf_pkg::ETHERTYPE_IPV4) begin
            o_push_class = tpdf_pkg::CLS_PASS;
        end else if (frame_len < tpdf_pkg::IPV4_MIN_LEN) begin
            o_push_class = tpdf_pkg::CLS_SHORT;
        end else if (n_ip_protocol != tpdf_pkg::PROTO_TCP) begin
            o_push_class = tpdf_pkg::CLS_PASS;
        end else if (frame_len < tcp_end) begin
            o_push_class = tpdf_pkg::CLS_TCP_SHORT;
        end else if (!i_cfg.port_enabled) begin
            o_push_class = tpdf_pkg::CLS_TCP_PASS;
        end else if (port_match) begin
            o_push_class = tpdf_pkg::CLS_TCP_DROP;
        end else begin
            o_push_class = tpdf_pkg::CLS_TCP_PASS;
        end
    end

    assign o_push = accept && i_s_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset       <= '0;
            r_ether_kind   <= '0;
            r_ip_protocol  <= '0;
            r_header_words <= '0;
            r_sport        <= '0;
            r_dst_port     <= '0;
        end else if (accept) begin
            if (i_s_tlast) begin
                r_offset       <= '0;
                r_ether_kind   <= '0;
                r_ip_protocol  <= '0;
                r_header_words <= '0;
                r_sport        <= '0;
                r_dst_port     <= '0;
            end else begin
                r_offset       <= n_offset;
                r_ether_kind   <= n_ether_kind;
                r_ip_protocol  <= n_ip_protocol;
                r_header_words <= n_header_words;
                r_sport        <= n_sport;
                r_dst_port     <= n_dst_port;
            end
        end
    end

endmodule

/* rtl/tpdf_queue.sv */
// ----------------------------------------------------------------------------
// TCP port drop filter request queue
// Short first-in first-out store of frame classes between front and back end.
// ----------------------------------------------------------------------------
module tpdf_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  tpdf_pkg::t_frame_class i_push_class,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_valid,
    output tpdf_pkg::t_frame_class o_class
);

    localparam int PW = tpdf_pkg::QUEUE_PTR_WIDTH;

    tpdf_pkg::t_frame_class r_mem [tpdf_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          do_pop;

    assign o_full  = (r_count == (PW+1)'(tpdf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_class = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

endmodule

/* rtl/tpdf_stats.sv */
// ----------------------------------------------------------------------------
// TCP port drop filter back end
// Updates the frame counters per request and holds the result for output.
// ----------------------------------------------------------------------------
module tpdf_stats #(
    parameter int COUNTER_WIDTH = tpdf_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    input  tpdf_pkg::t_frame_class               i_req_class,
    output logic                                 o_req_pop,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [tpdf_pkg::OUT_TDATA_WIDTH-1:0] o_m_tdata
);

    localparam int SW = tpdf_pkg::STAT_WIDTH;

    logic [COUNTER_WIDTH-1:0] r_total,   n_total;
    logic [COUNTER_WIDTH-1:0] r_tcp,     n_tcp;
    logic [COUNTER_WIDTH-1:0] r_dropped, n_dropped;
    logic [COUNTER_WIDTH-1:0] r_passed,  n_passed;
    logic [SW-1:0] ext_total, ext_tcp, ext_dropped, ext_passed;
    logic          r_out_valid;
    logic [tpdf_pkg::OUT_TDATA_WIDTH-1:0] r_out_data, n_out_data;
    logic          verdict;

    assign o_req_pop  = i_req_valid && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_total   = r_total + COUNTER_WIDTH'(1);
        n_tcp     = r_tcp;
        n_dropped = r_dropped;
        n_passed  = r_passed;
        verdict   = 1'b0;
        case (i_req_class)
            tpdf_pkg::CLS_SHORT: begin
            end
            tpdf_pkg::CLS_PASS: begin
                n_passed = r_passed + COUNTER_WIDTH'(1);
            end
            tpdf_pkg::CLS_TCP_SHORT: begin
                n_tcp = r_tcp + COUNTER_WIDTH'(1);
            end
            tpdf_pkg::CLS_TCP_PASS: begin
                n_tcp    = r_tcp + COUNTER_WIDTH'(1);
                n_passed = r_passed + COUNTER_WIDTH'(1);
            end
            tpdf_pkg::CLS_TCP_DROP: begin
                n_tcp     = r_tcp + COUNTER_WIDTH'(1);
                n_dropped = r_dropped + COUNTER_WIDTH'(1);
                verdict   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ext_total   = '0;
        ext_tcp     = '0;
        ext_dropped = '0;
        ext_passed  = '0;
        ext_total[COUNTER_WIDTH-1:0]   = n_total;
        ext_tcp[COUNTER_WIDTH-1:0]     = n_tcp;
        ext_dropped[COUNTER_WIDTH-1:0] = n_dropped;
        ext_passed[COUNTER_WIDTH-1:0]  = n_passed;
        n_out_data = '0;
        n_out_data[tpdf_pkg::OUT_FIELDS_WIDTH-1:0] =
            {ext_passed, ext_dropped, ext_tcp, ext_total, verdict};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_tcp       <= '0;
            r_dropped   <= '0;
            r_passed    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_req_pop) begin
                r_total     <= n_total;
                r_tcp       <= n_tcp;
                r_dropped   <= n_dropped;
                r_passed    <= n_passed;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

/* rtl/tcp_port_drop_filter.sv */
// ----------------------------------------------------------------------------
// TCP port drop filter
// Each result passes the request queue and the output register to o_m_tvalid.
// One byte per cycle unless queue_full; one result per cycle unless stalled.
// A four-entry request queue decouples the byte parser from the counters.
// Reset (synchronous, active low) clears counters, parser and queue;
// the drop port resets to 0 and port_enabled to 1.
// ----------------------------------------------------------------------------
module tcp_port_drop_filter #(
    parameter int COUNTER_WIDTH = tpdf_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [tpdf_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [tpdf_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [tpdf_pkg::IN_TDATA_WIDTH-1:0]  i_s_tdata,  // data_byte
    input  logic                                 i_s_tlast,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // verdict, total_count, tcp_count, dropped_count, passed_count, zero pad
    output logic [tpdf_pkg::OUT_TDATA_WIDTH-1:0] o_m_tdata
);

    tpdf_pkg::t_cfg         r_cfg;
    logic                   push;
    tpdf_pkg::t_frame_class push_class;
    logic                   queue_full;
    logic                   req_valid;
    tpdf_pkg::t_frame_class req_class;
    logic                   req_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drop_port    <= '0;
            r_cfg.port_enabled <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tpdf_pkg::CFG_IDX_DROP_PORT: begin
                    r_cfg.drop_port <= i_cfg_wdata;
                end
                tpdf_pkg::CFG_IDX_PORT_ENABLED: begin
                    r_cfg.port_enabled <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    tpdf_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_class (push_class)
    );

    tpdf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_class (push_class),
        .o_full       (queue_full),
        .i_pop        (req_pop),
        .o_valid      (req_valid),
        .o_class      (req_class)
    );

    tpdf_stats #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .i_req_class  (req_class),
        .o_req_pop    (req_pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

endmodule
